/* hdl/icalc_pkg.sv */
// Shared types for the integer calculator ALU: operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package icalc_pkg;

  // Operation codes carried in the operation field (6 and 7 are unused)
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_POW = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_DIV_ZERO     = 2'd1,
    ST_OVERFLOW     = 2'd2,
    ST_ZERO_NEG_POW = 2'd3
  } status_t;

  // Which unit an item needs, decoded from the captured operands
  typedef enum logic [1:0] {
    PATH_NOW = 2'd0,
    PATH_MUL = 2'd1,
    PATH_DIV = 2'd2,
    PATH_POW = 2'd3
  } path_t;

  // Load source for the shared shift register
  typedef enum logic [1:0] {
    PS_MUL_AB = 2'd0,
    PS_DIV    = 2'd1,
    PS_SQ     = 2'd2,
    PS_BASE   = 2'd3
  } psrc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_DIV,
    S_SQ_INIT,
    S_SQ_RUN,
    S_SQ_CHK,
    S_PM_INIT,
    S_PM_RUN,
    S_PM_CHK,
    S_NEXT,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  in_ready;
    logic  p_init;
    psrc_t p_src;
    logic  mul_step;
    logic  div_step;
    logic  acc_one;
    logic  acc_load;
    logic  set_ovf;
    logic  idx_dec;
    logic  res_load;
  } icalc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  in_valid;
    path_t path;
    logic  last;
    logic  prod_ovf;
    logic  exp_bit;
    logic  idx_zero;
    logic  out_free;
  } icalc_sts_t;

endpackage

`default_nettype wire

/* hdl/icalc_if.sv */
// Valid/ready channel interfaces for the calculator: operand request and result.
// No dependencies.
`default_nettype none

interface icalc_in_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;
  logic [2:0]                   operation;

  modport source (output valid, output operand_a, output operand_b, output operation,
                  input ready);
  modport sink (input valid, input operand_a, input operand_b, input operation,
                output ready);
endinterface

interface icalc_out_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic [1:0]                   status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

/* hdl/icalc_ctrl.sv */
// Sequencing state machine for the calculator: dispatch, multiply/divide runs,
// square-and-multiply power loop and result handoff. Uses icalc_pkg.
`default_nettype none

module icalc_ctrl
  import icalc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  icalc_sts_t sts,
  output icalc_cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.p_src  = PS_MUL_AB;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.path)
          PATH_NOW: state_next = S_FINISH;
          PATH_MUL: begin
            cmd.p_init = 1'b1;
            cmd.p_src  = PS_MUL_AB;
            state_next = S_MUL;
          end
          PATH_DIV: begin
            cmd.p_init = 1'b1;
            cmd.p_src  = PS_DIV;
            state_next = S_DIV;
          end
          PATH_POW: begin
            cmd.acc_one = 1'b1;
            state_next  = S_SQ_INIT;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.last) state_next = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.last) state_next = S_FINISH;
      end
      // acc = acc * acc
      S_SQ_INIT: begin
        cmd.p_init = 1'b1;
        cmd.p_src  = PS_SQ;
        state_next = S_SQ_RUN;
      end
      S_SQ_RUN: begin
        cmd.mul_step = 1'b1;
        if (sts.last) state_next = S_SQ_CHK;
      end
      S_SQ_CHK: begin
        if (sts.prod_ovf) begin
          cmd.set_ovf = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.acc_load = 1'b1;
          state_next   = sts.exp_bit ? S_PM_INIT : S_NEXT;
        end
      end
      // acc = acc * |base|
      S_PM_INIT: begin
        cmd.p_init = 1'b1;
        cmd.p_src  = PS_BASE;
        state_next = S_PM_RUN;
      end
      S_PM_RUN: begin
        cmd.mul_step = 1'b1;
        if (sts.last) state_next = S_PM_CHK;
      end
      S_PM_CHK: begin
        if (sts.prod_ovf) begin
          cmd.set_ovf = 1'b1;
          state_next  = S_FINISH;
        end else begin
          cmd.acc_load = 1'b1;
          state_next   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (sts.idx_zero) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_dec = 1'b1;
          state_next  = S_SQ_INIT;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/icalc_dp.sv */
// Calculator datapath: operand capture, shared shift-add multiplier / restoring
// divider register, power accumulator, result selection and output register.
// Uses icalc_pkg and the channel interfaces in icalc_if.sv.
`default_nettype none

module icalc_dp
  import icalc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  icalc_in_if.sink   req,
  icalc_out_if.source rsp,
  input  icalc_cmd_t cmd,
  output icalc_sts_t sts
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);   // step counter
  localparam int EW = $clog2(W);   // exponent bits worth iterating (exponent < W)
  localparam int IW = $clog2(EW);  // exponent bit index

  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] HALF   = {1'b1, {(W-1){1'b0}}};

  // Captured operands and magnitudes
  logic [W-1:0]   a_q, b_q, ma, mb;
  logic           na, nb;
  logic [2:0]     op_q;
  // Shared register: {hi, lo} = product, or {remainder, quotient}
  logic [2*W-1:0] p_q;
  logic [W-1:0]   mcand;
  logic [CW-1:0]  cnt;
  // Power loop
  logic [W-1:0]   acc;
  logic [IW-1:0]  idx;
  logic           ovf_q;
  // Output register
  logic [W-1:0]   value_q;
  status_t        status_q;
  logic           out_valid;

  logic [W-1:0]   a_in, b_in;
  logic           accept;
  logic [W:0]     msum, dshift, ddiff;
  logic           dge;
  logic [W-1:0]   rem_next;
  logic           rn;
  logic [W-1:0]   lim;
  logic [EW-1:0]  exp_bits;
  logic           mb_zero, b_zero, ma_zero, ma_one, big_exp;
  logic [W-1:0]   one_signed;
  logic [W-1:0]   res_value;
  status_t        res_status;
  logic [W-1:0]   q_mag, r_mag;
  logic           qn;

  assign a_in   = req.operand_a;
  assign b_in   = req.operand_b;
  assign accept = req.valid && req.ready;
  assign req.ready = cmd.in_ready;

  // Operand capture with sign/magnitude split
  always_ff @(posedge clk) begin
    if (accept) begin
      a_q  <= a_in;
      b_q  <= b_in;
      op_q <= req.operation;
      na   <= a_in[W-1];
      nb   <= b_in[W-1];
      ma   <= a_in[W-1] ? (~a_in + W'(1)) : a_in;
      mb   <= b_in[W-1] ? (~b_in + W'(1)) : b_in;
    end
  end

  // Shift-add step: add multiplicand on low bit, shift right
  assign msum = {1'b0, p_q[2*W-1:W]} + (p_q[0] ? {1'b0, mcand} : {(W+1){1'b0}});

  // Restoring divide step on magnitudes
  assign dshift   = p_q[2*W-1:W-1];
  assign dge      = dshift >= {1'b0, mb};
  assign ddiff    = dshift - {1'b0, mb};
  assign rem_next = dge ? ddiff[W-1:0] : dshift[W-1:0];

  // Shared multiply/divide register
  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      unique case (cmd.p_src)
        PS_MUL_AB: begin
          p_q   <= {{W{1'b0}}, b_q};
          mcand <= a_q;
        end
        PS_DIV: begin
          p_q   <= {{W{1'b0}}, ma};
          mcand <= mcand;
        end
        PS_SQ: begin
          p_q   <= {{W{1'b0}}, acc};
          mcand <= acc;
        end
        PS_BASE: begin
          p_q   <= {{W{1'b0}}, acc};
          mcand <= ma;
        end
        default: begin
          p_q   <= p_q;
          mcand <= mcand;
        end
      endcase
    end else if (cmd.mul_step) begin
      p_q <= {msum, p_q[W-1:1]};
    end else if (cmd.div_step) begin
      p_q <= {rem_next, p_q[W-2:0], dge};
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst || cmd.p_init) begin
      cnt <= '0;
    end else if (cmd.mul_step || cmd.div_step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Power accumulator, exponent bit index and overflow flag
  always_ff @(posedge clk) begin
    if (cmd.acc_one) begin
      acc <= W'(1);
    end else if (cmd.acc_load) begin
      acc <= p_q[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      ovf_q <= 1'b0;
    end else if (cmd.acc_one) begin
      idx   <= IW'(EW-1);
      ovf_q <= 1'b0;
    end else begin
      if (cmd.idx_dec) idx <= idx - 1'b1;
      if (cmd.set_ovf) ovf_q <= 1'b1;
    end
  end

  // Decode helpers
  assign rn         = na & b_q[0];
  assign lim        = rn ? HALF : MAXPOS;
  assign exp_bits   = b_q[EW-1:0];
  assign mb_zero    = (mb == '0);
  assign b_zero     = (b_q == '0);
  assign ma_zero    = (ma == '0);
  assign ma_one     = (ma == W'(1));
  assign big_exp    = (b_q >= W'(DATA_WIDTH));
  assign one_signed = rn ? {W{1'b1}} : W'(1);
  assign q_mag      = p_q[W-1:0];
  assign r_mag      = p_q[2*W-1:W];
  assign qn         = na ^ nb;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.in_valid = req.valid;
    sts.last     = (cnt == CW'(W-1));
    sts.prod_ovf = (p_q[2*W-1:W] != '0) || (p_q[W-1:0] > lim);
    sts.exp_bit  = exp_bits[idx];
    sts.idx_zero = (idx == '0);
    sts.out_free = !out_valid || rsp.ready;
    unique case (op_q)
      OP_MUL:         sts.path = PATH_MUL;
      OP_DIV, OP_REM: sts.path = mb_zero ? PATH_NOW : PATH_DIV;
      OP_POW:         sts.path = (nb || b_zero || ma_zero || ma_one || big_exp) ?
                                 PATH_NOW : PATH_POW;
      default:        sts.path = PATH_NOW;
    endcase
  end

  // Result selection
  always_comb begin
    res_value  = '0;
    res_status = ST_OK;
    unique case (op_q)
      OP_ADD: res_value = a_q + b_q;
      OP_SUB: res_value = a_q - b_q;
      OP_MUL: res_value = p_q[W-1:0];
      OP_DIV: begin
        if (mb_zero) begin
          res_status = ST_DIV_ZERO;
        end else if (!qn && q_mag[W-1]) begin
          // most negative over minus one
          res_value  = MAXPOS;
          res_status = ST_OVERFLOW;
        end else begin
          res_value = qn ? (~q_mag + W'(1)) : q_mag;
        end
      end
      OP_REM: begin
        if (mb_zero) begin
          res_status = ST_DIV_ZERO;
        end else begin
          res_value = na ? (~r_mag + W'(1)) : r_mag;
        end
      end
      OP_POW: begin
        if (nb) begin
          if (ma_zero) res_status = ST_ZERO_NEG_POW;
          else if (ma_one) res_value = one_signed;
        end else if (b_zero) begin
          res_value = W'(1);
        end else if (ma_zero) begin
          res_value = '0;
        end else if (ma_one) begin
          res_value = one_signed;
        end else if (big_exp || ovf_q) begin
          res_value  = lim;
          res_status = ST_OVERFLOW;
        end else begin
          res_value = rn ? (~acc + W'(1)) : acc;
        end
      end
      default: res_value = '0;
    endcase
  end

  // Output register: holds a finished result until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      value_q  <= res_value;
      status_q <= res_status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.value  = value_q;
  assign rsp.status = status_q;

endmodule

`default_nettype wire

/* hdl/integer_calculator_alu_top.sv */
// Integer calculator ALU: add, subtract, multiply, divide, remainder and power on two
// signed DATA_WIDTH-bit operands, one result (value, status) per request. One item is
// worked on at a time. Add, subtract and every case settled by the operands alone skip
// the shift register; multiply, divide and remainder run through the shared
// shift-add/restoring-divide register, which retires one bit per cycle. Power runs
// square-and-multiply over the low clog2(DATA_WIDTH) exponent bits, squaring for each
// bit and multiplying by the base magnitude for a set bit; overflow ends it early.
// A result still held in the output register delays the load of the next one.
// The next request can be taken in the cycle after the load. The result register
// frees the controller while the result waits.
// Uses icalc_pkg, icalc_if.sv, icalc_ctrl and icalc_dp.
`default_nettype none

module integer_calculator_alu_top
  import icalc_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  icalc_in_if.sink    req,
  icalc_out_if.source rsp
);

  icalc_cmd_t cmd;
  icalc_sts_t sts;

  icalc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  icalc_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

`default_nettype wire
